// ----- hdl/wsfp_pkg.sv -----
package wsfp_pkg;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [0:0] OPER_FEED    = 1'b0;
    localparam logic [0:0] OPER_RESTART = 1'b1;

    localparam logic [0:0] CFG_CONTROL_LIMIT = 1'b0;
    localparam logic [0:0] CFG_MESSAGE_LIMIT = 1'b1;

    localparam logic [6:0]  CONTROL_LIMIT_RST = 7'd125;
    localparam logic [31:0] MESSAGE_LIMIT_RST = 32'd65536;

    localparam logic [2:0] KIND_DATA_BYTE    = 3'd0;
    localparam logic [2:0] KIND_CONTROL_BYTE = 3'd1;
    localparam logic [2:0] KIND_TEXT         = 3'd2;
    localparam logic [2:0] KIND_BINARY       = 3'd3;
    localparam logic [2:0] KIND_PING         = 3'd4;
    localparam logic [2:0] KIND_PONG         = 3'd5;
    localparam logic [2:0] KIND_CLOSE        = 3'd6;
    localparam logic [2:0] KIND_ERROR        = 3'd7;

    localparam logic [2:0] ERR_RSV      = 3'd0;
    localparam logic [2:0] ERR_MASKED   = 3'd1;
    localparam logic [2:0] ERR_CONTROL  = 3'd2;
    localparam logic [2:0] ERR_SEQUENCE = 3'd3;
    localparam logic [2:0] ERR_OPCODE   = 3'd4;
    localparam logic [2:0] ERR_TOO_BIG  = 3'd5;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0]  LEN7_EXT16  = 7'd126;
    localparam logic [6:0]  LEN7_EXT64  = 7'd127;
    localparam logic [3:0]  HDR_SHORT   = 4'd2;
    localparam logic [3:0]  HDR_MEDIUM  = 4'd4;
    localparam logic [3:0]  HDR_LONG    = 4'd10;
    localparam logic [7:0]  RSV_MASK    = 8'h70;
    localparam logic [15:0] CLOSE_DEFAULT = 16'd1005;

    typedef struct packed {
        logic [0:0] operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  payload_byte;
        logic [31:0] event_length;
        logic [15:0] close_code;
        logic [2:0]  error_code;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic      vld0;
        logic      vld1;
        t_out_item first;
        t_out_item second;
    } t_res_push;

endpackage

// ----- hdl/websocket_frame_parser.sv -----
// Each input transaction is registered and parsed once the queue has room for two results; its
// results, one or two, are written together to a four-entry output queue, from which the
// first result is offered and a second result, where there is one, follows it.
// One byte is taken every clock while the output side keeps pace; the queue room sets the rate.
// Reset is synchronous and active low; it clears the parser and the queue and returns the
// limits to 125 and 65536 bytes.
module websocket_frame_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wsfp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wsfp_pkg::t_out_item o_out_data,
    input  logic                i_cfg_wr_en,
    input  logic [0:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    wsfp_pkg::t_res_push push;
    logic                room;

    wsfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_room      (room),
        .o_push      (push)
    );

    wsfp_res_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- hdl/wsfp_res_queue.sv -----
module wsfp_res_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wsfp_pkg::t_res_push i_push,
    output logic                o_room,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wsfp_pkg::t_out_item o_out_data
);

    wsfp_pkg::t_out_item r_mem [wsfp_pkg::Q_DEPTH];

    logic [wsfp_pkg::Q_PTR_W-1:0] r_wr;
    logic [wsfp_pkg::Q_PTR_W-1:0] r_rd;
    logic [wsfp_pkg::Q_CNT_W-1:0] r_count;
    logic [wsfp_pkg::Q_CNT_W-1:0] push_n;
    logic                         pop;

    assign push_n      = wsfp_pkg::Q_CNT_W'(i_push.vld0) + wsfp_pkg::Q_CNT_W'(i_push.vld1);
    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_data  = r_mem[r_rd];
    assign o_room      = (r_count <= wsfp_pkg::Q_CNT_W'(wsfp_pkg::Q_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.vld0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.vld1) begin
            r_mem[r_wr + wsfp_pkg::Q_PTR_W'(1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + push_n[wsfp_pkg::Q_PTR_W-1:0];
            r_rd    <= r_rd + wsfp_pkg::Q_PTR_W'(pop);
            r_count <= r_count + push_n - wsfp_pkg::Q_CNT_W'(pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= wsfp_pkg::Q_CNT_W'(wsfp_pkg::Q_DEPTH))
        else $error("result queue count beyond its depth");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.vld1 |-> i_push.vld0)
        else $error("second result written without a first");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_room |-> !i_push.vld0)
        else $error("result written into a queue without room");

endmodule

// ----- hdl/wsfp_core.sv -----
module wsfp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wsfp_pkg::t_in_item  i_in_data,
    input  logic                i_cfg_wr_en,
    input  logic [0:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_room,
    output wsfp_pkg::t_res_push o_push
);

    logic               r_in_vld;
    wsfp_pkg::t_in_item r_in;
    logic [6:0]         r_control_limit;
    logic [31:0]        r_message_limit;

    logic [3:0]  r_hdr_cnt,   n_hdr_cnt;
    logic [3:0]  r_hdr_need,  n_hdr_need;
    logic [7:0]  r_b0,        n_b0;
    logic [7:0]  r_b1,        n_b1;
    logic [63:0] r_ext,       n_ext;
    logic [63:0] r_remain,    n_remain;
    logic [3:0]  r_frame_op,  n_frame_op;
    logic        r_final,     n_final;
    logic        r_in_payload, n_in_payload;
    logic [1:0]  r_msg_op,    n_msg_op;
    logic [31:0] r_msg_len,   n_msg_len;
    logic [6:0]  r_ctl_len,   n_ctl_len;
    logic [15:0] r_close,     n_close;
    logic        r_failed,    n_failed;

    logic        proc;
    logic [7:0]  byte_in;
    logic [3:0]  cnt_inc;
    logic [7:0]  hdr_b0;
    logic [7:0]  hdr_b1;
    logic [6:0]  len7;
    logic [3:0]  need_calc;
    logic [3:0]  need_now;
    logic [63:0] full_len;
    logic [3:0]  op;
    logic        fin;
    logic        is_start;
    logic [31:0] msg_len_eff;
    logic [1:0]  msg_op_eff;
    logic [31:0] diff;
    logic        too_big;
    logic        ctl_big;
    logic        err_vld;
    logic [2:0]  err_code;
    logic [6:0]  new_ctl_len;
    logic [15:0] new_close;
    logic [31:0] new_msg_len;

    function automatic wsfp_pkg::t_out_item f_finish(
        input logic [3:0]  fop,
        input logic [6:0]  clen,
        input logic [15:0] ccode,
        input logic [1:0]  mop,
        input logic [31:0] mlen
    );
        wsfp_pkg::t_out_item res;
        res = '0;
        res.last_of_run = 1'b1;
        case (fop)
            wsfp_pkg::OP_PING: begin
                res.event_kind   = wsfp_pkg::KIND_PING;
                res.event_length = {25'd0, clen};
            end
            wsfp_pkg::OP_PONG: begin
                res.event_kind   = wsfp_pkg::KIND_PONG;
                res.event_length = {25'd0, clen};
            end
            wsfp_pkg::OP_CLOSE: begin
                res.event_kind   = wsfp_pkg::KIND_CLOSE;
                res.event_length = {25'd0, clen};
                res.close_code   = (clen >= 7'd2) ? ccode : wsfp_pkg::CLOSE_DEFAULT;
            end
            default: begin
                res.event_kind   = (mop == wsfp_pkg::OP_TEXT[1:0]) ?
                                   wsfp_pkg::KIND_TEXT : wsfp_pkg::KIND_BINARY;
                res.event_length = mlen;
            end
        endcase
        return res;
    endfunction

    assign proc       = r_in_vld && i_room;
    assign o_in_ready = !r_in_vld || proc;
    assign byte_in    = r_in.rx_byte;

    always_comb begin
        cnt_inc   = r_hdr_cnt + 4'd1;
        hdr_b0    = (r_hdr_cnt == 4'd0) ? byte_in : r_b0;
        hdr_b1    = (r_hdr_cnt == 4'd1) ? byte_in : r_b1;
        len7      = hdr_b1[6:0];
        if (len7 == wsfp_pkg::LEN7_EXT16) begin
            need_calc = wsfp_pkg::HDR_MEDIUM;
        end else if (len7 == wsfp_pkg::LEN7_EXT64) begin
            need_calc = wsfp_pkg::HDR_LONG;
        end else begin
            need_calc = wsfp_pkg::HDR_SHORT;
        end
        need_now  = (r_hdr_cnt == 4'd1) ? need_calc : r_hdr_need;
        full_len  = (len7 < wsfp_pkg::LEN7_EXT16) ? {57'd0, len7} : {r_ext[55:0], byte_in};
        op        = hdr_b0[3:0];
        fin       = hdr_b0[7];
        is_start  = (op == wsfp_pkg::OP_TEXT) || (op == wsfp_pkg::OP_BINARY);
        msg_len_eff = is_start ? 32'd0 : r_msg_len;
        msg_op_eff  = is_start ? op[1:0] : r_msg_op;
        diff      = r_message_limit - msg_len_eff;
        too_big   = (msg_len_eff > r_message_limit) || (full_len > {32'd0, diff});
        ctl_big   = (full_len[63:7] != '0) || (full_len[6:0] > r_control_limit);

        err_vld  = 1'b1;
        err_code = wsfp_pkg::ERR_RSV;
        if ((hdr_b0 & wsfp_pkg::RSV_MASK) != 8'd0) begin
            err_code = wsfp_pkg::ERR_RSV;
        end else if (hdr_b1[7]) begin
            err_code = wsfp_pkg::ERR_MASKED;
        end else begin
            case (op)
                wsfp_pkg::OP_CLOSE, wsfp_pkg::OP_PING, wsfp_pkg::OP_PONG: begin
                    err_vld  = !fin || ctl_big;
                    err_code = wsfp_pkg::ERR_CONTROL;
                end
                wsfp_pkg::OP_TEXT, wsfp_pkg::OP_BINARY: begin
                    if (r_msg_op != 2'd0) begin
                        err_code = wsfp_pkg::ERR_SEQUENCE;
                    end else begin
                        err_vld  = too_big;
                        err_code = wsfp_pkg::ERR_TOO_BIG;
                    end
                end
                wsfp_pkg::OP_CONT: begin
                    if (r_msg_op == 2'd0) begin
                        err_code = wsfp_pkg::ERR_SEQUENCE;
                    end else begin
                        err_vld  = too_big;
                        err_code = wsfp_pkg::ERR_TOO_BIG;
                    end
                end
                default: begin
                    err_code = wsfp_pkg::ERR_OPCODE;
                end
            endcase
        end

        new_ctl_len = r_ctl_len + 7'd1;
        new_msg_len = r_msg_len + 32'd1;
        if (r_ctl_len == 7'd0) begin
            new_close = {byte_in, 8'd0};
        end else if (r_ctl_len == 7'd1) begin
            new_close = r_close | {8'd0, byte_in};
        end else begin
            new_close = r_close;
        end
    end

    always_comb begin
        n_hdr_cnt    = r_hdr_cnt;
        n_hdr_need   = r_hdr_need;
        n_b0         = r_b0;
        n_b1         = r_b1;
        n_ext        = r_ext;
        n_remain     = r_remain;
        n_frame_op   = r_frame_op;
        n_final      = r_final;
        n_in_payload = r_in_payload;
        n_msg_op     = r_msg_op;
        n_msg_len    = r_msg_len;
        n_ctl_len    = r_ctl_len;
        n_close      = r_close;
        n_failed     = r_failed;
        o_push       = '0;

        if (proc) begin
            if (r_in.operation == wsfp_pkg::OPER_RESTART) begin
                n_hdr_cnt    = 4'd0;
                n_hdr_need   = wsfp_pkg::HDR_SHORT;
                n_remain     = '0;
                n_frame_op   = wsfp_pkg::OP_CONT;
                n_final      = 1'b0;
                n_in_payload = 1'b0;
                n_msg_op     = 2'd0;
                n_msg_len    = '0;
                n_ctl_len    = '0;
                n_close      = '0;
                n_failed     = 1'b0;
            end else if (!r_failed) begin
                if (!r_in_payload) begin
                    n_hdr_cnt = cnt_inc;
                    case (r_hdr_cnt)
                        4'd0: n_b0 = byte_in;
                        4'd1: begin
                            n_b1       = byte_in;
                            n_ext      = '0;
                            n_hdr_need = need_calc;
                        end
                        default: n_ext = {r_ext[55:0], byte_in};
                    endcase
                    if (cnt_inc == need_now) begin
                        if (err_vld) begin
                            n_failed                  = 1'b1;
                            o_push.vld0               = 1'b1;
                            o_push.first.event_kind   = wsfp_pkg::KIND_ERROR;
                            o_push.first.error_code   = err_code;
                            o_push.first.last_of_run  = 1'b1;
                        end else begin
                            n_frame_op   = op;
                            n_final      = fin;
                            n_remain     = full_len;
                            n_in_payload = 1'b1;
                            if (op[3]) begin
                                n_ctl_len = '0;
                                n_close   = '0;
                            end else if (is_start) begin
                                n_msg_op  = op[1:0];
                                n_msg_len = '0;
                            end
                            if (full_len == '0) begin
                                n_in_payload = 1'b0;
                                n_hdr_cnt    = 4'd0;
                                n_hdr_need   = wsfp_pkg::HDR_SHORT;
                                if (op[3] || fin) begin
                                    o_push.vld0  = 1'b1;
                                    o_push.first = f_finish(op, 7'd0, 16'd0,
                                                            msg_op_eff, msg_len_eff);
                                    if (!op[3]) begin
                                        n_msg_op = 2'd0;
                                    end
                                end
                            end
                        end
                    end
                end else begin
                    o_push.vld0               = 1'b1;
                    o_push.first.payload_byte = byte_in;
                    if (r_frame_op[3]) begin
                        o_push.first.event_kind = wsfp_pkg::KIND_CONTROL_BYTE;
                        n_ctl_len = new_ctl_len;
                        n_close   = new_close;
                    end else begin
                        o_push.first.event_kind = wsfp_pkg::KIND_DATA_BYTE;
                        n_msg_len = new_msg_len;
                    end
                    n_remain = r_remain - 64'd1;
                    o_push.first.last_of_run = 1'b1;
                    if (r_remain == 64'd1) begin
                        n_in_payload = 1'b0;
                        n_hdr_cnt    = 4'd0;
                        n_hdr_need   = wsfp_pkg::HDR_SHORT;
                        if (r_frame_op[3] || r_final) begin
                            o_push.first.last_of_run = 1'b0;
                            o_push.vld1   = 1'b1;
                            o_push.second = f_finish(r_frame_op, new_ctl_len, new_close,
                                                     r_msg_op, new_msg_len);
                            if (!r_frame_op[3]) begin
                                n_msg_op = 2'd0;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld        <= 1'b0;
            r_control_limit <= wsfp_pkg::CONTROL_LIMIT_RST;
            r_message_limit <= wsfp_pkg::MESSAGE_LIMIT_RST;
            r_hdr_cnt       <= 4'd0;
            r_hdr_need      <= wsfp_pkg::HDR_SHORT;
            r_remain        <= '0;
            r_frame_op      <= wsfp_pkg::OP_CONT;
            r_final         <= 1'b0;
            r_in_payload    <= 1'b0;
            r_msg_op        <= 2'd0;
            r_msg_len       <= '0;
            r_ctl_len       <= '0;
            r_close         <= '0;
            r_failed        <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    wsfp_pkg::CFG_CONTROL_LIMIT: r_control_limit <= i_cfg_data[6:0];
                    wsfp_pkg::CFG_MESSAGE_LIMIT: r_message_limit <= i_cfg_data;
                    default: r_control_limit <= r_control_limit;
                endcase
            end
            r_hdr_cnt    <= n_hdr_cnt;
            r_hdr_need   <= n_hdr_need;
            r_remain     <= n_remain;
            r_frame_op   <= n_frame_op;
            r_final      <= n_final;
            r_in_payload <= n_in_payload;
            r_msg_op     <= n_msg_op;
            r_msg_len    <= n_msg_len;
            r_ctl_len    <= n_ctl_len;
            r_close      <= n_close;
            r_failed     <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        r_b0  <= n_b0;
        r_b1  <= n_b1;
        r_ext <= n_ext;
    end

    a_error_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.vld0 && o_push.first.event_kind == wsfp_pkg::KIND_ERROR) |=> r_failed)
        else $error("error reported without entering the failed state");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in.operation == wsfp_pkg::OPER_RESTART) |=> (!r_failed && !r_in_payload))
        else $error("restart left the parser busy or failed");

    a_push_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.vld0 |-> (proc && i_room))
        else $error("result produced without a processed transaction");

endmodule

// ----- verif/websocket_frame_parser_tb.sv -----
module websocket_frame_parser_tb;
    import wsfp_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam logic [3:0]  NO_MESSAGE   = 4'h0;
    localparam logic [3:0]  OP_RESERVED  = 4'h3;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_data   = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_item   o_out_data;

    // Parser image kept alongside the block.
    logic [7:0]  hdr_bytes[10];
    logic [3:0]  hdr_count;
    logic [3:0]  hdr_needed;
    logic [63:0] frame_len;
    logic [63:0] frame_got;
    logic [3:0]  frame_op;
    logic        frame_final;
    logic        in_body;
    logic [3:0]  msg_op;
    logic [31:0] msg_len;
    logic [6:0]  ctl_len;
    logic [15:0] close_bytes;
    logic        stream_failed;
    logic [6:0]  ctl_limit;
    logic [31:0] msg_limit;

    t_out_item expected_events[$];
    int        mismatches = 0;
    int        items_taken = 0;
    bit        steady = 1'b0;
    int        hold_requests = 0;
    int        holds_taken = 0;
    int        hold_cycles_left = 0;

    websocket_frame_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("websocket_frame_parser regression: fail");
        $finish;
    end

    function automatic void restart_parser();
        hdr_count     = '0;
        hdr_needed    = HDR_SHORT;
        frame_len     = '0;
        frame_got     = '0;
        frame_op      = '0;
        frame_final   = 1'b0;
        in_body       = 1'b0;
        msg_op        = NO_MESSAGE;
        msg_len       = '0;
        ctl_len       = '0;
        close_bytes   = '0;
        stream_failed = 1'b0;
    endfunction

    function automatic t_out_item make_event(logic [2:0] kind, logic [7:0] data,
                                             logic [31:0] len, logic [15:0] code,
                                             logic [2:0] err);
        t_out_item e;
        e.event_kind   = kind;
        e.payload_byte = data;
        e.event_length = len;
        e.close_code   = code;
        e.error_code   = err;
        e.last_of_run  = 1'b0;
        return e;
    endfunction

    // Returns -1 for an acceptable header, otherwise the error code.
    function automatic int vet_header();
        logic [6:0] len7;
        len7 = hdr_bytes[1][6:0];
        if ((hdr_bytes[0] & RSV_MASK) != 8'h00) return ERR_RSV;
        if (hdr_bytes[1][7]) return ERR_MASKED;
        frame_final = hdr_bytes[0][7];
        frame_op    = hdr_bytes[0][3:0];
        if (len7 < LEN7_EXT16) begin
            frame_len = {57'd0, len7};
        end else if (len7 == LEN7_EXT16) begin
            frame_len = {48'd0, hdr_bytes[2], hdr_bytes[3]};
        end else begin
            frame_len = {hdr_bytes[2], hdr_bytes[3], hdr_bytes[4], hdr_bytes[5],
                         hdr_bytes[6], hdr_bytes[7], hdr_bytes[8], hdr_bytes[9]};
        end
        frame_got = '0;
        case (frame_op)
            OP_CLOSE, OP_PING, OP_PONG: begin
                if (!frame_final || frame_len > {57'd0, ctl_limit}) return ERR_CONTROL;
                ctl_len     = '0;
                close_bytes = '0;
                return -1;
            end
            OP_TEXT, OP_BINARY: begin
                if (msg_op != NO_MESSAGE) return ERR_SEQUENCE;
                msg_op  = frame_op;
                msg_len = '0;
            end
            OP_CONT: begin
                if (msg_op == NO_MESSAGE) return ERR_SEQUENCE;
            end
            default: begin
                return ERR_OPCODE;
            end
        endcase
        if (msg_len > msg_limit || frame_len > {32'd0, msg_limit - msg_len}) return ERR_TOO_BIG;
        return -1;
    endfunction

    function automatic bit close_frame(output t_out_item e);
        in_body    = 1'b0;
        hdr_count  = '0;
        hdr_needed = HDR_SHORT;
        case (frame_op)
            OP_PING: e = make_event(KIND_PING, 8'd0, {25'd0, ctl_len}, 16'd0, 3'd0);
            OP_PONG: e = make_event(KIND_PONG, 8'd0, {25'd0, ctl_len}, 16'd0, 3'd0);
            OP_CLOSE: begin
                e = make_event(KIND_CLOSE, 8'd0, {25'd0, ctl_len},
                               (ctl_len >= 7'd2) ? close_bytes : CLOSE_DEFAULT, 3'd0);
            end
            default: begin
                if (!frame_final) return 1'b0;
                e = make_event((msg_op == OP_TEXT) ? KIND_TEXT : KIND_BINARY, 8'd0,
                               msg_len, 16'd0, 3'd0);
                msg_op = NO_MESSAGE;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void parse_byte(t_in_item it);
        t_out_item evs[2];
        t_out_item e;
        int        n;
        int        err;
        logic      ctl;
        n = 0;
        if (it.operation == OPER_RESTART) begin
            restart_parser();
        end else if (!stream_failed) begin
            if (!in_body) begin
                if (hdr_count < 4'd10) hdr_bytes[hdr_count] = it.rx_byte;
                hdr_count++;
                if (hdr_count == 4'd2) begin
                    if (hdr_bytes[1][6:0] == LEN7_EXT16) hdr_needed = HDR_MEDIUM;
                    else if (hdr_bytes[1][6:0] == LEN7_EXT64) hdr_needed = HDR_LONG;
                    else hdr_needed = HDR_SHORT;
                end
                if (hdr_count >= hdr_needed) begin
                    err = vet_header();
                    if (err >= 0) begin
                        stream_failed = 1'b1;
                        evs[n++] = make_event(KIND_ERROR, 8'd0, 32'd0, 16'd0, 3'(err));
                    end else begin
                        in_body = 1'b1;
                        if (frame_len == 64'd0 && close_frame(e)) evs[n++] = e;
                    end
                end
            end else begin
                ctl = frame_op[3];
                if (ctl) begin
                    if (ctl_len == 7'd0) close_bytes = {it.rx_byte, 8'h00};
                    else if (ctl_len == 7'd1) close_bytes = close_bytes | {8'h00, it.rx_byte};
                    ctl_len = ctl_len + 7'd1;
                end else begin
                    msg_len = msg_len + 32'd1;
                end
                evs[n++] = make_event(ctl ? KIND_CONTROL_BYTE : KIND_DATA_BYTE, it.rx_byte,
                                      32'd0, 16'd0, 3'd0);
                frame_got = frame_got + 64'd1;
                if (frame_got == frame_len && close_frame(e)) evs[n++] = e;
            end
        end
        if (n > 0) evs[n - 1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++) expected_events.push_back(evs[i]);
    endfunction

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", msg);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) note_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_events.size() == 0) begin
                note_mismatch($sformatf("result 0x%0h with none expected", o_out_data));
            end else begin
                want = expected_events.pop_front();
                check_field("event_kind", want.event_kind, o_out_data.event_kind);
                check_field("payload_byte", want.payload_byte, o_out_data.payload_byte);
                check_field("event_length", want.event_length, o_out_data.event_length);
                check_field("close_code", want.close_code, o_out_data.close_code);
                check_field("error_code", want.error_code, o_out_data.error_code);
                check_field("last_of_run", want.last_of_run, o_out_data.last_of_run);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_cycles_left > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles_left--;
        end else if (hold_requests != holds_taken) begin
            holds_taken++;
            hold_cycles_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (steady) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 32);
        end
    end

    task automatic send_item(logic [0:0] op, logic [7:0] data);
        t_in_item it;
        int       gap;
        it.operation = op;
        it.rx_byte   = data;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (op == OPER_RESTART || !stream_failed) items_taken++;
        parse_byte(it);
        gap = 0;
        while (!steady && $urandom_range(99) < 32) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [0:0] index, logic [31:0] value);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (index == CFG_CONTROL_LIMIT) ctl_limit = value[6:0];
        else msg_limit = value;
    endtask

    function automatic logic [7:0] first_byte(logic fin, logic [3:0] op);
        return {fin, 3'b000, op};
    endfunction

    task automatic send_random_frame();
        logic [3:0]  op;
        logic [7:0]  b0;
        logic        mask;
        logic [63:0] len;
        int          pick;
        int          form;
        int          k;
        bit          aborted;
        pick = $urandom_range(99);
        if (pick < 5) begin
            repeat ($urandom_range(1, 4)) send_item(OPER_FEED, 8'($urandom));
            send_item(OPER_RESTART, 8'($urandom));
        end else begin
            if (pick < 30) begin
                case ($urandom_range(2))
                    0: op = OP_CLOSE;
                    1: op = OP_PING;
                    default: op = OP_PONG;
                endcase
                b0  = first_byte($urandom_range(19) != 0, op);
                len = ($urandom_range(9) == 0) ? $urandom_range(125) : $urandom_range(ctl_limit);
            end else begin
                if (msg_op == NO_MESSAGE) op = $urandom_range(1) ? OP_TEXT : OP_BINARY;
                else op = OP_CONT;
                if ($urandom_range(99) < 6) op = (op == OP_CONT) ? OP_TEXT : OP_CONT;
                b0  = first_byte(1'($urandom_range(1)), op);
                len = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(12);
            end
            mask = 1'b0;
            case ($urandom_range(24))
                0: b0[6:4] = 3'($urandom_range(1, 7));
                1: mask = 1'b1;
                2: b0[3:0] = 4'($urandom_range(15));
                default: ;
            endcase
            k = $urandom_range(99);
            if (k < 3) begin
                len  = {32'($urandom) | 32'd1, 32'($urandom)};
                form = 2;
            end else if (k < 10) begin
                form = 1;
            end else if (k < 15) begin
                form = 2;
            end else begin
                form = (len < 64'd126) ? 0 : 1;
            end
            send_item(OPER_FEED, b0);
            case (form)
                0: send_item(OPER_FEED, {mask, len[6:0]});
                1: begin
                    send_item(OPER_FEED, {mask, LEN7_EXT16});
                    send_item(OPER_FEED, len[15:8]);
                    send_item(OPER_FEED, len[7:0]);
                end
                default: begin
                    send_item(OPER_FEED, {mask, LEN7_EXT64});
                    for (int i = 7; i >= 0; i--) send_item(OPER_FEED, len[8 * i +: 8]);
                end
            endcase
            aborted = 1'b0;
            for (k = 0; k < len && !stream_failed && !aborted; k++) begin
                if ($urandom_range(199) == 0) begin
                    send_item(OPER_RESTART, 8'($urandom));
                    aborted = 1'b1;
                end else begin
                    send_item(OPER_FEED, 8'($urandom));
                end
            end
            if (stream_failed) begin
                if ($urandom_range(3) == 0) send_item(OPER_FEED, 8'($urandom));
                send_item(OPER_RESTART, 8'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic(int n_items);
        int target;
        target = items_taken + n_items;
        while (items_taken < target) send_random_frame();
    endtask

    task automatic test_basic_frames();
        send_item(OPER_FEED, first_byte(1'b1, OP_TEXT));
        send_item(OPER_FEED, 8'd1);
        send_item(OPER_FEED, 8'h00);
        send_item(OPER_FEED, first_byte(1'b1, OP_PING));
        send_item(OPER_FEED, 8'd0);
        send_item(OPER_FEED, first_byte(1'b1, OP_CLOSE));
        send_item(OPER_FEED, 8'd2);
        send_item(OPER_FEED, 8'hFF);
        send_item(OPER_FEED, 8'hFF);
        send_item(OPER_FEED, first_byte(1'b1, OP_CLOSE));
        send_item(OPER_FEED, 8'd1);
        send_item(OPER_FEED, 8'h5A);
        send_item(OPER_FEED, first_byte(1'b0, OP_BINARY));
        send_item(OPER_FEED, 8'd0);
        send_item(OPER_FEED, first_byte(1'b1, OP_CONT));
        send_item(OPER_FEED, 8'd1);
        send_item(OPER_FEED, 8'hFF);
        send_item(OPER_FEED, first_byte(1'b1, OP_PONG));
        send_item(OPER_FEED, 8'd0);
        send_item(OPER_RESTART, 8'hFF);
    endtask

    task automatic test_error_codes();
        send_item(OPER_FEED, {1'b1, 3'b111, OP_TEXT});
        send_item(OPER_FEED, 8'd0);
        send_item(OPER_FEED, first_byte(1'b1, OP_TEXT));
        send_item(OPER_RESTART, 8'h00);
        send_item(OPER_FEED, first_byte(1'b1, OP_TEXT));
        send_item(OPER_FEED, {1'b1, 7'd0});
        send_item(OPER_RESTART, 8'h00);
        send_item(OPER_FEED, first_byte(1'b0, OP_PING));
        send_item(OPER_FEED, 8'd0);
        send_item(OPER_RESTART, 8'h00);
        send_item(OPER_FEED, first_byte(1'b1, OP_PING));
        send_item(OPER_FEED, {1'b0, LEN7_EXT16});
        send_item(OPER_FEED, 8'd0);
        send_item(OPER_FEED, 8'd126);
        send_item(OPER_RESTART, 8'h00);
        send_item(OPER_FEED, first_byte(1'b1, OP_CONT));
        send_item(OPER_FEED, 8'd0);
        send_item(OPER_RESTART, 8'h00);
        send_item(OPER_FEED, first_byte(1'b1, OP_RESERVED));
        send_item(OPER_FEED, 8'd0);
        send_item(OPER_RESTART, 8'h00);
        send_item(OPER_FEED, first_byte(1'b1, OP_BINARY));
        send_item(OPER_FEED, {1'b0, LEN7_EXT64});
        repeat (8) send_item(OPER_FEED, 8'hFF);
        send_item(OPER_RESTART, 8'h00);
    endtask

    task automatic test_limit_change();
        send_item(OPER_FEED, first_byte(1'b0, OP_TEXT));
        send_item(OPER_FEED, 8'd5);
        repeat (5) send_item(OPER_FEED, 8'($urandom));
        write_register(CFG_MESSAGE_LIMIT, 32'd3);
        send_item(OPER_FEED, first_byte(1'b1, OP_CONT));
        send_item(OPER_FEED, 8'd0);
        send_item(OPER_RESTART, 8'h00);
        write_register(CFG_MESSAGE_LIMIT, MESSAGE_LIMIT_RST);
    endtask

    task automatic test_limit_sweep();
        write_register(CFG_CONTROL_LIMIT, 32'd0);
        write_register(CFG_MESSAGE_LIMIT, 32'd0);
        test_random_traffic(200);
        write_register(CFG_CONTROL_LIMIT, 32'd125);
        write_register(CFG_MESSAGE_LIMIT, 32'hFFFF_FFFF);
        test_random_traffic(250);
        write_register(CFG_CONTROL_LIMIT, $urandom_range(1, 124));
        write_register(CFG_MESSAGE_LIMIT, $urandom_range(1, 400));
        test_random_traffic(250);
        write_register(CFG_CONTROL_LIMIT, {25'd0, CONTROL_LIMIT_RST});
        write_register(CFG_MESSAGE_LIMIT, MESSAGE_LIMIT_RST);
    endtask

    task automatic test_backpressure();
        hold_requests++;
        test_random_traffic(100);
        drain();
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        test_random_traffic(200);
        drain();
        steady = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < 10; i++) hdr_bytes[i] = 8'h00;
        ctl_limit = CONTROL_LIMIT_RST;
        msg_limit = MESSAGE_LIMIT_RST;
        restart_parser();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_frames();
        test_error_codes();
        test_limit_change();
        test_random_traffic(350);
        test_limit_sweep();
        test_backpressure();
        test_steady_stream();
        drain();
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("websocket_frame_parser regression: pass");
        end else begin
            $display("websocket_frame_parser regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/wsfp_pkg.sv
hdl/wsfp_res_queue.sv
hdl/wsfp_core.sv
hdl/websocket_frame_parser.sv
verif/websocket_frame_parser_tb.sv
